/* rtl/vmrp_pkg.sv */
package vmrp_pkg;

   localparam int OBJECT_BYTES = 544;
   localparam int OBJ_AW = 10;
   localparam logic [15:0] OBJ_HIGH_TABLE = 16'h0200;

   localparam logic [5:0] OFF_OBJ_BASE_LO = 6'h02;
   localparam logic [5:0] OFF_OBJ_BASE_HI = 6'h03;
   localparam logic [5:0] OFF_OBJ_DATA_WR = 6'h04;
   localparam logic [5:0] OFF_STEP_CTRL   = 6'h15;
   localparam logic [5:0] OFF_VADDR_LO    = 6'h16;
   localparam logic [5:0] OFF_VADDR_HI    = 6'h17;
   localparam logic [5:0] OFF_VDATA_LO_WR = 6'h18;
   localparam logic [5:0] OFF_VDATA_HI_WR = 6'h19;
   localparam logic [5:0] OFF_MATRIX_A    = 6'h1B;
   localparam logic [5:0] OFF_MATRIX_B    = 6'h1C;
   localparam logic [5:0] OFF_PAL_PTR     = 6'h21;
   localparam logic [5:0] OFF_PAL_DATA_WR = 6'h22;
   localparam logic [5:0] OFF_PROD_LO     = 6'h34;
   localparam logic [5:0] OFF_PROD_MID    = 6'h35;
   localparam logic [5:0] OFF_PROD_HI     = 6'h36;
   localparam logic [5:0] OFF_CNT_LATCH   = 6'h37;
   localparam logic [5:0] OFF_OBJ_DATA_RD = 6'h38;
   localparam logic [5:0] OFF_VDATA_LO_RD = 6'h39;
   localparam logic [5:0] OFF_VDATA_HI_RD = 6'h3A;
   localparam logic [5:0] OFF_PAL_DATA_RD = 6'h3B;
   localparam logic [5:0] OFF_HCOUNT      = 6'h3C;
   localparam logic [5:0] OFF_VCOUNT      = 6'h3D;
   localparam logic [5:0] OFF_STATUS_A    = 6'h3E;
   localparam logic [5:0] OFF_STATUS_B    = 6'h3F;

   localparam logic [7:0] STATUS_A_VALUE = 8'h01;
   localparam logic [7:0] STATUS_B_VALUE = 8'h03;

   localparam logic ACTION_READ  = 1'b0;
   localparam logic ACTION_WRITE = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_RLD_ISSUE,
      ST_RLD_TAKE,
      ST_WR2,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic clear;
      logic capture;
      logic exec;
      logic rld_take;
      logic wr2;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic need_reload;
      logic need_wr2;
   } status_type;

endpackage

/* rtl/video_memory_register_port_core.sv */
// Register port of a picture processor: one bus access per request beat, one byte back.
// The request channel carries req_action (0 read, 1 write), req_reg_offset (address
// minus 0x2100) and req_write_data. Every request beat yields exactly one response
// beat on rsp_read_data; writes answer 0.
// The block works on one beat at a time. Most accesses pass from acceptance through
// an execute state to the response state; writes to the video address registers also
// pass the reload issue and take states to reload the read prefetch word from video
// memory, and a completing paired object write a second write state, as each memory has one write port.
// A new request is accepted at the earliest in the cycle after the previous response is
// taken, so the block never takes a new beat before it is through with the last one.
// After reset the block sweeps all memories to zero, one entry a cycle, over the larger
// of VIDEO_BYTES/2 and 544 entries; req_stall stays high meanwhile.
// While rsp_stall is high the response beat holds and no new request is taken.
module video_memory_register_port_core import vmrp_pkg::*; #(
   parameter int VIDEO_BYTES = 65536,
   parameter int PALETTE_BYTES = 512
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_action,
   input  logic [5:0] req_reg_offset,
   input  logic [7:0] req_write_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_read_data
);

   cmd_type    cmd;
   status_type status;

   vmrp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   vmrp_datapath #(
      .VIDEO_BYTES   (VIDEO_BYTES),
      .PALETTE_BYTES (PALETTE_BYTES)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_action     (req_action),
      .req_reg_offset (req_reg_offset),
      .req_write_data (req_write_data),
      .rsp_read_data  (rsp_read_data)
   );

endmodule

/* rtl/vmrp_ctrl.sv */
module vmrp_ctrl import vmrp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (status.need_reload) state_in = ST_RLD_ISSUE;
            else if (status.need_wr2) state_in = ST_WR2;
            else state_in = ST_RESP;
         end
         ST_RLD_ISSUE: state_in = ST_RLD_TAKE;
         ST_RLD_TAKE: state_in = ST_RESP;
         ST_WR2: state_in = ST_RESP;
         ST_RESP: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_CLEAR: cmd.clear = 1'b1;
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.capture = req_valid;
         end
         ST_EXEC: cmd.exec = 1'b1;
         ST_RLD_ISSUE: ;
         ST_RLD_TAKE: cmd.rld_take = 1'b1;
         ST_WR2: cmd.wr2 = 1'b1;
         ST_RESP: rsp_valid = 1'b1;
         default: ;
      endcase
   end

endmodule

/* rtl/vmrp_datapath.sv */
module vmrp_datapath import vmrp_pkg::*; #(
   parameter int VIDEO_BYTES = 65536,
   parameter int PALETTE_BYTES = 512
) (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   output status_type status,
   input  logic       req_action,
   input  logic [5:0] req_reg_offset,
   input  logic [7:0] req_write_data,
   output logic [7:0] rsp_read_data
);

   localparam int VW = VIDEO_BYTES / 2;
   localparam int PW = PALETTE_BYTES / 2;
   localparam int VAW = $clog2(VW);
   localparam int PAW = $clog2(PW);
   localparam int CLR_N = (VW > OBJECT_BYTES) ? VW : OBJECT_BYTES;
   localparam int CW = $clog2(CLR_N);

   logic [15:0] video_mem [VW];
   logic [15:0] pal_mem [PW];
   logic [7:0]  obj_mem [OBJECT_BYTES];

   logic [15:0] vid_q_ff, pal_q_ff;
   logic [7:0]  obj_q_ff;

   logic [CW-1:0] clr_ff;
   logic        act_ff;
   logic [5:0]  off_ff;
   logic [7:0]  dat_ff;
   logic [7:0]  rdata_ff, rdata_in;

   logic [15:0] vaddr_ff, vaddr_in;
   logic [2:0]  step_ff, step_in;
   logic [15:0] pref_ff, pref_in;
   logic [7:0]  pptr_ff, pptr_in;
   logic        pphase_ff, pphase_in;
   logic [7:0]  phold_ff, phold_in;
   logic [9:0]  obase_ff, obase_in;
   logic [15:0] optr_ff, optr_in;
   logic        ophase_ff, ophase_in;
   logic [7:0]  ohold_ff, ohold_in;
   logic [7:0]  latch_ff, latch_in;
   logic [15:0] ma_ff, ma_in;
   logic [7:0]  mb_ff, mb_in;
   logic [23:0] prod_ff, prod_in;
   logic        hph_ff, hph_in;
   logic        vph_ff, vph_in;

   logic            vid_we, pal_we, obj_we;
   logic [VAW-1:0]  vid_wa;
   logic [PAW-1:0]  pal_wa;
   logic [OBJ_AW-1:0] obj_wa;
   logic [15:0]     vid_wd, pal_wd;
   logic [7:0]      obj_wd;

   logic v_in_range, p_in_range, o_in_range, o1_in_range;
   logic [15:0] optr_plus1;
   logic [15:0] step_amt;
   logic signed [15:0] mul_a;
   logic signed [7:0]  mul_b;
   logic signed [23:0] mul_p;

   assign v_in_range  = {1'b0, vaddr_ff} < 17'(VW);
   assign p_in_range  = {1'b0, pptr_ff} < 9'(PW);
   assign o_in_range  = optr_ff < 16'(OBJECT_BYTES);
   assign optr_plus1  = optr_ff + 16'd1;
   assign o1_in_range = optr_plus1 < 16'(OBJECT_BYTES);
   assign mul_p = mul_a * mul_b;

   always_comb begin
      case (step_ff[1:0])
         2'd0: step_amt = 16'd1;
         2'd1: step_amt = 16'd32;
         default: step_amt = 16'd128;
      endcase
   end

   assign status.clear_last = (clr_ff == CW'(CLR_N - 1));
   assign status.need_reload = (act_ff == ACTION_WRITE) &&
      (off_ff == OFF_VADDR_LO || off_ff == OFF_VADDR_HI);
   assign status.need_wr2 = (act_ff == ACTION_WRITE) && (off_ff == OFF_OBJ_DATA_WR) &&
      (optr_ff < OBJ_HIGH_TABLE) && ophase_ff;
   assign rsp_read_data = rdata_ff;

   always_comb begin
      vaddr_in = vaddr_ff; step_in = step_ff; pref_in = pref_ff;
      pptr_in = pptr_ff; pphase_in = pphase_ff; phold_in = phold_ff;
      obase_in = obase_ff; optr_in = optr_ff; ophase_in = ophase_ff;
      ohold_in = ohold_ff; latch_in = latch_ff; ma_in = ma_ff; mb_in = mb_ff;
      prod_in = prod_ff; hph_in = hph_ff; vph_in = vph_ff;
      rdata_in = rdata_ff;
      mul_a = signed'(ma_ff);
      mul_b = signed'(mb_ff);
      vid_we = 1'b0; vid_wa = vaddr_ff[VAW-1:0]; vid_wd = vid_q_ff;
      pal_we = 1'b0; pal_wa = pptr_ff[PAW-1:0]; pal_wd = {dat_ff, phold_ff};
      obj_we = 1'b0; obj_wa = optr_ff[OBJ_AW-1:0]; obj_wd = dat_ff;

      if (cmd.clear) begin
         vid_we = {1'b0, clr_ff} < (CW + 1)'(VW);
         vid_wa = clr_ff[VAW-1:0];
         vid_wd = '0;
         pal_we = {1'b0, clr_ff} < (CW + 1)'(PW);
         pal_wa = clr_ff[PAW-1:0];
         pal_wd = '0;
         obj_we = {1'b0, clr_ff} < (CW + 1)'(OBJECT_BYTES);
         obj_wa = clr_ff[OBJ_AW-1:0];
         obj_wd = '0;
      end

      if (cmd.rld_take && v_in_range) pref_in = vid_q_ff;

      if (cmd.wr2) begin
         obj_we = o1_in_range;
         obj_wa = optr_plus1[OBJ_AW-1:0];
         obj_wd = dat_ff;
         optr_in = optr_ff + 16'd2;
         ophase_in = 1'b0;
      end

      if (cmd.exec && act_ff == ACTION_WRITE) begin
         rdata_in = '0;
         case (off_ff)
            OFF_OBJ_BASE_LO: begin
               obase_in = {obase_ff[9], dat_ff, 1'b0};
               optr_in = {6'd0, obase_ff[9], dat_ff, 1'b0};
               ophase_in = 1'b0;
            end
            OFF_OBJ_BASE_HI: begin
               obase_in = {dat_ff[0], obase_ff[8:0]};
               optr_in = {6'd0, dat_ff[0], obase_ff[8:0]};
               ophase_in = 1'b0;
            end
            OFF_OBJ_DATA_WR: begin
               if (optr_ff >= OBJ_HIGH_TABLE) begin
                  obj_we = o_in_range;
                  obj_wd = dat_ff;
                  optr_in = optr_plus1;
               end else if (!ophase_ff) begin
                  ohold_in = dat_ff;
                  ophase_in = 1'b1;
               end else begin
                  obj_we = o_in_range;
                  obj_wd = ohold_ff;
               end
            end
            OFF_STEP_CTRL: step_in = {dat_ff[7], dat_ff[1:0]};
            OFF_VADDR_LO: vaddr_in = {vaddr_ff[15:8], dat_ff};
            OFF_VADDR_HI: vaddr_in = {dat_ff, vaddr_ff[7:0]};
            OFF_VDATA_LO_WR: begin
               vid_we = v_in_range;
               vid_wd = {vid_q_ff[15:8], dat_ff};
               if (!step_ff[2]) vaddr_in = vaddr_ff + step_amt;
            end
            OFF_VDATA_HI_WR: begin
               vid_we = v_in_range;
               vid_wd = {dat_ff, vid_q_ff[7:0]};
               if (step_ff[2]) vaddr_in = vaddr_ff + step_amt;
            end
            OFF_MATRIX_A: begin
               ma_in = {dat_ff, latch_ff};
               latch_in = dat_ff;
               mul_a = signed'({dat_ff, latch_ff});
               prod_in = mul_p;
            end
            OFF_MATRIX_B: begin
               mb_in = dat_ff;
               latch_in = dat_ff;
               mul_b = signed'(dat_ff);
               prod_in = mul_p;
            end
            OFF_PAL_PTR: begin
               pptr_in = dat_ff;
               pphase_in = 1'b0;
            end
            OFF_PAL_DATA_WR: begin
               if (!pphase_ff) begin
                  phold_in = dat_ff;
                  pphase_in = 1'b1;
               end else begin
                  pal_we = p_in_range;
                  pptr_in = pptr_ff + 8'd1;
                  pphase_in = 1'b0;
               end
            end
            default: begin
               if (off_ff inside {[6'h0D:6'h14], 6'h1D, 6'h1E}) latch_in = dat_ff;
            end
         endcase
      end else if (cmd.exec) begin
         rdata_in = '0;
         case (off_ff)
            OFF_PROD_LO: rdata_in = prod_ff[7:0];
            OFF_PROD_MID: rdata_in = prod_ff[15:8];
            OFF_PROD_HI: rdata_in = prod_ff[23:16];
            OFF_CNT_LATCH: begin
               hph_in = 1'b0;
               vph_in = 1'b0;
            end
            OFF_OBJ_DATA_RD: begin
               if (o_in_range) rdata_in = obj_q_ff;
               optr_in = optr_plus1;
            end
            OFF_VDATA_LO_RD: begin
               rdata_in = pref_ff[7:0];
               if (!step_ff[2]) begin
                  if (v_in_range) pref_in = vid_q_ff;
                  vaddr_in = vaddr_ff + step_amt;
               end
            end
            OFF_VDATA_HI_RD: begin
               rdata_in = pref_ff[15:8];
               if (step_ff[2]) begin
                  if (v_in_range) pref_in = vid_q_ff;
                  vaddr_in = vaddr_ff + step_amt;
               end
            end
            OFF_PAL_DATA_RD: begin
               if (p_in_range) rdata_in = pphase_ff ? pal_q_ff[15:8] : pal_q_ff[7:0];
               if (pphase_ff) pptr_in = pptr_ff + 8'd1;
               pphase_in = !pphase_ff;
            end
            OFF_HCOUNT: hph_in = !hph_ff;
            OFF_VCOUNT: vph_in = !vph_ff;
            OFF_STATUS_A: rdata_in = STATUS_A_VALUE;
            OFF_STATUS_B: begin
               rdata_in = STATUS_B_VALUE;
               hph_in = 1'b0;
               vph_in = 1'b0;
            end
            default: rdata_in = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (vid_we) video_mem[vid_wa] <= vid_wd;
      vid_q_ff <= video_mem[vaddr_ff[VAW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (pal_we) pal_mem[pal_wa] <= pal_wd;
      pal_q_ff <= pal_mem[pptr_ff[PAW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (obj_we) obj_mem[obj_wa] <= obj_wd;
      obj_q_ff <= obj_mem[optr_ff[OBJ_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff <= req_action;
         off_ff <= req_reg_offset;
         dat_ff <= req_write_data;
      end
      rdata_ff <= rdata_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         vaddr_ff <= '0; step_ff <= '0; pref_ff <= '0;
         pptr_ff <= '0; pphase_ff <= 1'b0; phold_ff <= '0;
         obase_ff <= '0; optr_ff <= '0; ophase_ff <= 1'b0; ohold_ff <= '0;
         latch_ff <= '0; ma_ff <= '0; mb_ff <= '0; prod_ff <= '0;
         hph_ff <= 1'b0; vph_ff <= 1'b0;
      end else begin
         if (cmd.clear) clr_ff <= clr_ff + CW'(1);
         vaddr_ff <= vaddr_in; step_ff <= step_in; pref_ff <= pref_in;
         pptr_ff <= pptr_in; pphase_ff <= pphase_in; phold_ff <= phold_in;
         obase_ff <= obase_in; optr_ff <= optr_in; ophase_ff <= ophase_in;
         ohold_ff <= ohold_in;
         latch_ff <= latch_in; ma_ff <= ma_in; mb_ff <= mb_in; prod_ff <= prod_in;
         hph_ff <= hph_in; vph_ff <= vph_in;
      end
   end

endmodule
